// ----- hw/rtl/scsm_pkg.sv -----
// Shared types and constants for the sliding color sequence matcher.
// No dependencies.
`timescale 1ns / 1ps
package scsm_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_IGNORE = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_META,
      ST_META_W,
      ST_READ,
      ST_READ_W,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic lib_we;
      logic id_we;
      logic len_we;
      logic qry_we;
   } store_we_type;

   localparam int ID_W    = 16;
   localparam int COLOR_W = 24;
   localparam int CHAN_W  = 8;
   localparam int SAD_W   = 10;
   localparam int QUO_W   = 18;
   localparam int STEP_W  = 5;
   localparam int SUM_W   = 26;
   localparam int SCORE_W = 23;

   // 3 * 255 * 256
   localparam logic [QUO_W-1:0]   PAIR_NUM  = 18'd195840;
   localparam logic [SCORE_W-1:0] SCORE_SAT = 23'h7FFFFF;

endpackage

// ----- hw/rtl/scsm_req_if.sv -----
// Request channel: valid/ready plus one color beat.
// Depends on nothing.
`timescale 1ns / 1ps
interface scsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] surface_id;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic        last_color;

   modport source (output valid, req_type, surface_id, red, green, blue, last_color,
                   input ready);
   modport sink (input valid, req_type, surface_id, red, green, blue, last_color,
                 output ready);
endinterface

// ----- hw/rtl/scsm_rsp_if.sv -----
// Response channel: valid/ready plus one match result beat.
// Depends on nothing.
`timescale 1ns / 1ps
interface scsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] query_surface_id;
   logic [15:0] best_library_id;
   logic [22:0] best_score;
   logic        found;
   logic        truncated;

   modport source (output valid, query_surface_id, best_library_id, best_score, found,
                   truncated, input ready);
   modport sink (input valid, query_surface_id, best_library_id, best_score, found,
                 truncated, output ready);
endinterface

// ----- hw/rtl/scsm_div.sv -----
// Restoring divider: PAIR_NUM / divisor, one quotient bit per cycle.
// A zero divisor yields all ones (the saturated pair score). Uses scsm_pkg.
`timescale 1ns / 1ps
module scsm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [scsm_pkg::SAD_W-1:0]  divisor,
   output logic                        done,
   output logic [scsm_pkg::QUO_W-1:0]  quotient
);
   import scsm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SAD_W-1:0]  rem_ff, rem_in;
   logic [SAD_W-1:0]  dvs_ff, dvs_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [SAD_W:0]    rem_sh;
   logic [SAD_W:0]    rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff, PAIR_NUM[step_ff]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUO_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[SAD_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[SAD_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
   a_done_end : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held");
`endif
endmodule

// ----- hw/rtl/scsm_store.sv -----
// Storage: library colors, library ids and lengths, query colors.
// Single-port write, registered read. Uses scsm_pkg.
`timescale 1ns / 1ps
module scsm_store #(
   parameter int MAX_SURFACES = 16,
   parameter int MAX_COLORS   = 32,
   localparam int DEPTH = MAX_SURFACES * MAX_COLORS,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int SW = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1,
   localparam int IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1,
   localparam int LW = $clog2(MAX_COLORS + 1)
) (
   input  logic                          clock,
   input  scsm_pkg::store_we_type        we,
   input  logic [AW-1:0]                 lib_waddr,
   input  logic [scsm_pkg::COLOR_W-1:0]  lib_wdata,
   input  logic [AW-1:0]                 lib_raddr,
   output logic [scsm_pkg::COLOR_W-1:0]  lib_rdata,
   input  logic [SW-1:0]                 meta_waddr,
   input  logic [scsm_pkg::ID_W-1:0]     id_wdata,
   input  logic [LW-1:0]                 len_wdata,
   input  logic [SW-1:0]                 meta_raddr,
   output logic [scsm_pkg::ID_W-1:0]     id_rdata,
   output logic [LW-1:0]                 len_rdata,
   input  logic [IW-1:0]                 q_waddr,
   input  logic [scsm_pkg::COLOR_W-1:0]  q_wdata,
   input  logic [IW-1:0]                 q_raddr,
   output logic [scsm_pkg::COLOR_W-1:0]  q_rdata
);
   import scsm_pkg::*;

   logic [COLOR_W-1:0] lib_mem [DEPTH];
   logic [ID_W-1:0]    id_mem  [MAX_SURFACES];
   logic [LW-1:0]      len_mem [MAX_SURFACES];
   logic [COLOR_W-1:0] q_mem   [MAX_COLORS];

   always_ff @(posedge clock) begin
      if (we.lib_we) begin
         lib_mem[lib_waddr] <= lib_wdata;
      end
      lib_rdata <= lib_mem[lib_raddr];
   end

   always_ff @(posedge clock) begin
      if (we.id_we) begin
         id_mem[meta_waddr] <= id_wdata;
      end
      if (we.len_we) begin
         len_mem[meta_waddr] <= len_wdata;
      end
      id_rdata  <= id_mem[meta_raddr];
      len_rdata <= len_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (we.qry_we) begin
         q_mem[q_waddr] <= q_wdata;
      end
      q_rdata <= q_mem[q_raddr];
   end
endmodule

// ----- hw/rtl/sliding_color_sequence_matcher.sv -----
// Load/clear/query-color beats: one per cycle. A final query beat starts the walk:
// per surface a metadata read (META, META_W), per overlapping color pair a read,
// register, 18-step divider and accumulate, then the result is posted in ST_DONE.
// The walk holds req ready low; the result sits in an output register.
// Synchronous reset empties library and query; memory contents stay undefined.
`timescale 1ns / 1ps
module sliding_color_sequence_matcher #(
   parameter int MAX_SURFACES = 16,
   parameter int MAX_COLORS   = 32
) (
   input  logic          clock,
   input  logic          reset,
   scsm_req_if.sink      req_bus,
   scsm_rsp_if.source    rsp_bus
);
   import scsm_pkg::*;

   localparam int DEPTH = MAX_SURFACES * MAX_COLORS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1;
   localparam int CW = $clog2(MAX_SURFACES + 1);
   localparam int IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int LW = $clog2(MAX_COLORS + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]      lib_count_ff, lib_count_in;
   logic               lib_open_ff, lib_open_in;
   logic               lib_trunc_ff, lib_trunc_in;
   logic               lib_drop_ff, lib_drop_in;
   logic [LW-1:0]      cur_len_ff, cur_len_in;
   logic [LW-1:0]      qlen_ff, qlen_in;
   logic               qtrunc_ff, qtrunc_in;
   logic [ID_W-1:0]    qid_ff, qid_in;
   logic [SW-1:0]      s_ff, s_in;
   logic [LW-1:0]      ll_ff, ll_in;
   logic [ID_W-1:0]    cid_ff, cid_in;
   logic [IW-1:0]      i0_ff, i0_in;
   logic [IW-1:0]      j0_ff, j0_in;
   logic [IW-1:0]      i_ff, i_in;
   logic [IW-1:0]      j_ff, j_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   sbest_ff, sbest_in;
   logic [SUM_W-1:0]   best_ff, best_in;
   logic [ID_W-1:0]    bid_ff, bid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_qid_ff, rsp_qid_in;
   logic [ID_W-1:0]    rsp_bid_ff, rsp_bid_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_trunc_ff, rsp_trunc_in;

   logic               req_acc;
   logic               have_room;
   logic               drop_eff;
   logic [SW-1:0]      tail_idx;
   logic [LW-1:0]      load_len;
   logic               len_room;
   logic               q_room;
   logic               is_load;
   logic               query_end;
   logic               i_last;
   logic               j_last;
   logic               pair_end;
   logic               off_down;
   logic               off_up;
   logic               last_surf;
   logic [SUM_W-1:0]   sum_new;
   logic [SUM_W-1:0]   off_best;
   logic               rsp_load;
   logic               div_start;
   logic               div_done;
   logic [QUO_W-1:0]   div_q;
   logic [SAD_W-1:0]   sad;
   logic [CHAN_W:0]    d_r, d_g, d_b;

   store_we_type       st_we;
   logic [AW-1:0]      lib_waddr, lib_raddr;
   logic [COLOR_W-1:0] lib_rdata, q_rdata;
   logic [ID_W-1:0]    id_rdata;
   logic [LW-1:0]      len_rdata;

   assign req_acc   = req_bus.valid && req_bus.ready;
   assign have_room = lib_count_ff < CW'(MAX_SURFACES);
   assign drop_eff  = lib_open_ff ? lib_drop_ff : !have_room;
   assign tail_idx  = lib_open_ff ? SW'(lib_count_ff - 1'b1) : SW'(lib_count_ff);
   assign load_len  = lib_open_ff ? cur_len_ff : '0;
   assign len_room  = load_len < LW'(MAX_COLORS);
   assign q_room    = qlen_ff < LW'(MAX_COLORS);
   assign is_load   = req_acc && (req_bus.req_type == REQ_LOAD);
   assign query_end = req_acc && (req_bus.req_type == REQ_QUERY) && req_bus.last_color;

   assign i_last    = LW'(i_ff) == (qlen_ff - 1'b1);
   assign j_last    = LW'(j_ff) == (ll_ff - 1'b1);
   assign pair_end  = i_last || j_last;
   assign off_down  = (i0_ff == '0) && (j0_ff != '0);
   assign off_up    = LW'(i0_ff) < (qlen_ff - 1'b1);
   assign last_surf = CW'(s_ff) == (lib_count_ff - 1'b1);
   assign sum_new   = sum_ff + SUM_W'(div_q);
   assign off_best  = (sum_new > sbest_ff) ? sum_new : sbest_ff;

   assign d_r = (lib_rdata[23:16] > q_rdata[23:16]) ?
                {1'b0, lib_rdata[23:16] - q_rdata[23:16]} :
                {1'b0, q_rdata[23:16] - lib_rdata[23:16]};
   assign d_g = (lib_rdata[15:8] > q_rdata[15:8]) ?
                {1'b0, lib_rdata[15:8] - q_rdata[15:8]} :
                {1'b0, q_rdata[15:8] - lib_rdata[15:8]};
   assign d_b = (lib_rdata[7:0] > q_rdata[7:0]) ?
                {1'b0, lib_rdata[7:0] - q_rdata[7:0]} :
                {1'b0, q_rdata[7:0] - lib_rdata[7:0]};
   assign sad = SAD_W'(d_r) + SAD_W'(d_g) + SAD_W'(d_b);

   assign st_we.lib_we = is_load && !drop_eff && len_room;
   assign st_we.len_we = is_load && !drop_eff && len_room;
   assign st_we.id_we  = is_load && !lib_open_ff && have_room;
   assign st_we.qry_we = req_acc && (req_bus.req_type == REQ_QUERY) && q_room;
   assign lib_waddr = AW'(tail_idx) * AW'(MAX_COLORS) + AW'(load_len[IW-1:0]);
   assign lib_raddr = AW'(s_ff) * AW'(MAX_COLORS) + AW'(j_ff);

   scsm_store #(
      .MAX_SURFACES (MAX_SURFACES),
      .MAX_COLORS   (MAX_COLORS)
   ) u_store (
      .clock      (clock),
      .we         (st_we),
      .lib_waddr  (lib_waddr),
      .lib_wdata  ({req_bus.red, req_bus.green, req_bus.blue}),
      .lib_raddr  (lib_raddr),
      .lib_rdata  (lib_rdata),
      .meta_waddr (tail_idx),
      .id_wdata   (req_bus.surface_id),
      .len_wdata  (load_len + 1'b1),
      .meta_raddr (s_ff),
      .id_rdata   (id_rdata),
      .len_rdata  (len_rdata),
      .q_waddr    (qlen_ff[IW-1:0]),
      .q_wdata    ({req_bus.red, req_bus.green, req_bus.blue}),
      .q_raddr    (i_ff),
      .q_rdata    (q_rdata)
   );

   scsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (sad),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_end) begin
               state_in = (lib_count_ff == '0) ? ST_DONE : ST_META;
            end
         end
         ST_META:   state_in = ST_META_W;
         ST_META_W: state_in = ST_READ;
         ST_READ:   state_in = ST_READ_W;
         ST_READ_W: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               if (!pair_end || off_down || off_up) begin
                  state_in = ST_READ;
               end else if (last_surf) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_META;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_bus.ready = 1'b0;
      div_start     = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_bus.ready = 1'b1;
         ST_READ_W: div_start = 1'b1;
         ST_DONE:   rsp_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      lib_count_in = lib_count_ff;
      lib_open_in  = lib_open_ff;
      lib_trunc_in = lib_trunc_ff;
      lib_drop_in  = lib_drop_ff;
      cur_len_in   = cur_len_ff;
      qlen_in      = qlen_ff;
      qtrunc_in    = qtrunc_ff;
      qid_in       = qid_ff;
      s_in         = s_ff;
      ll_in        = ll_ff;
      cid_in       = cid_ff;
      i0_in        = i0_ff;
      j0_in        = j0_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sum_in       = sum_ff;
      sbest_in     = sbest_ff;
      best_in      = best_ff;
      bid_in       = bid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_bus.req_type)
                  REQ_LOAD: begin
                     if (!lib_open_ff) begin
                        lib_open_in = 1'b1;
                        if (have_room) begin
                           lib_drop_in  = 1'b0;
                           lib_count_in = lib_count_ff + 1'b1;
                        end else begin
                           lib_drop_in  = 1'b1;
                           lib_trunc_in = 1'b1;
                        end
                     end
                     if (!drop_eff) begin
                        if (len_room) begin
                           cur_len_in = load_len + 1'b1;
                        end else begin
                           lib_trunc_in = 1'b1;
                        end
                     end
                     if (req_bus.last_color) begin
                        lib_open_in = 1'b0;
                        lib_drop_in = 1'b0;
                     end
                  end
                  REQ_QUERY: begin
                     if (q_room) begin
                        qlen_in = qlen_ff + 1'b1;
                     end else begin
                        qtrunc_in = 1'b1;
                     end
                     if (req_bus.last_color) begin
                        qid_in  = req_bus.surface_id;
                        s_in    = '0;
                        best_in = '0;
                        bid_in  = '0;
                     end
                  end
                  REQ_CLEAR: begin
                     lib_count_in = '0;
                     lib_open_in  = 1'b0;
                     lib_trunc_in = 1'b0;
                     lib_drop_in  = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_META_W: begin
            ll_in    = len_rdata;
            cid_in   = id_rdata;
            i0_in    = '0;
            j0_in    = IW'(len_rdata - 1'b1);
            i_in     = '0;
            j_in     = IW'(len_rdata - 1'b1);
            sum_in   = '0;
            sbest_in = '0;
         end
         ST_DIV: begin
            if (div_done) begin
               if (!pair_end) begin
                  i_in   = i_ff + 1'b1;
                  j_in   = j_ff + 1'b1;
                  sum_in = sum_new;
               end else begin
                  sbest_in = off_best;
                  sum_in   = '0;
                  if (off_down) begin
                     j0_in = j0_ff - 1'b1;
                     i_in  = '0;
                     j_in  = j0_ff - 1'b1;
                  end else if (off_up) begin
                     i0_in = i0_ff + 1'b1;
                     j0_in = '0;
                     i_in  = i0_ff + 1'b1;
                     j_in  = '0;
                  end else begin
                     if ((s_ff == '0) || (off_best > best_ff)) begin
                        best_in = off_best;
                        bid_in  = cid_ff;
                     end
                     if (!last_surf) begin
                        s_in = s_ff + 1'b1;
                     end
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               qlen_in   = '0;
               qtrunc_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_qid_in   = rsp_qid_ff;
      rsp_bid_in   = rsp_bid_ff;
      rsp_score_in = rsp_score_ff;
      rsp_found_in = rsp_found_ff;
      rsp_trunc_in = rsp_trunc_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_qid_in   = qid_ff;
         rsp_bid_in   = bid_ff;
         rsp_score_in = (best_ff > SUM_W'(SCORE_SAT)) ? SCORE_SAT : best_ff[SCORE_W-1:0];
         rsp_found_in = lib_count_ff != '0;
         rsp_trunc_in = qtrunc_ff || lib_trunc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lib_count_ff <= '0;
         lib_open_ff  <= 1'b0;
         lib_trunc_ff <= 1'b0;
         lib_drop_ff  <= 1'b0;
         qlen_ff      <= '0;
         qtrunc_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lib_count_ff <= lib_count_in;
         lib_open_ff  <= lib_open_in;
         lib_trunc_ff <= lib_trunc_in;
         lib_drop_ff  <= lib_drop_in;
         qlen_ff      <= qlen_in;
         qtrunc_ff    <= qtrunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_len_ff   <= cur_len_in;
      qid_ff       <= qid_in;
      s_ff         <= s_in;
      ll_ff        <= ll_in;
      cid_ff       <= cid_in;
      i0_ff        <= i0_in;
      j0_ff        <= j0_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      sum_ff       <= sum_in;
      sbest_ff     <= sbest_in;
      best_ff      <= best_in;
      bid_ff       <= bid_in;
      rsp_qid_ff   <= rsp_qid_in;
      rsp_bid_ff   <= rsp_bid_in;
      rsp_score_ff <= rsp_score_in;
      rsp_found_ff <= rsp_found_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.query_surface_id = rsp_qid_ff;
   assign rsp_bus.best_library_id  = rsp_bid_ff;
   assign rsp_bus.best_score       = rsp_score_ff;
   assign rsp_bus.found            = rsp_found_ff;
   assign rsp_bus.truncated        = rsp_trunc_ff;

`ifndef SYNTHESIS
   a_count_max : assert property (@(posedge clock) disable iff (reset)
      lib_count_ff <= CW'(MAX_SURFACES))
      else $error("library count past limit");
   a_qlen_max : assert property (@(posedge clock) disable iff (reset)
      qlen_ff <= LW'(MAX_COLORS))
      else $error("query length past limit");
   a_walk_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ((LW'(i_ff) < qlen_ff) && (LW'(j_ff) < ll_ff)))
      else $error("pair index outside overlap");
   a_div_state : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider result outside wait state");
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_score_ff)))
      else $error("pending result overwritten");
`endif
endmodule
